[src/sha1_hash_macros.svh]
// Assertion macros shared by the SHA-1 hash RTL.
`ifndef SHA1_HASH_MACROS_SVH
`define SHA1_HASH_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SHA1_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SHA1_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/sha1_pkg.sv]
// Shared types, constants and round functions of the SHA-1 hash block.
package sha1_pkg;

    localparam int DIGEST_WORDS = 5;
    localparam int BLOCK_WORDS  = 16;

    typedef logic [31:0] word_t;
    typedef logic [4:0]  wcount_t;
    typedef logic [6:0]  round_t;
    typedef logic [2:0]  windex_t;
    typedef word_t [DIGEST_WORDS-1:0] digest_t;

    localparam word_t K0 = 32'h5A827999;
    localparam word_t K1 = 32'h6ED9EBA1;
    localparam word_t K2 = 32'h8F1BBCDC;
    localparam word_t K3 = 32'hCA62C1D6;

    // Index 0 is h0.
    localparam digest_t IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                              32'hEFCDAB89, 32'h67452301};

    localparam word_t   PAD_WORD   = 32'h0000_0080;
    localparam wcount_t WC_FULL    = 5'd16;
    localparam wcount_t WC_LEN     = 5'd14;
    localparam round_t  LAST_ROUND = 7'd79;
    localparam windex_t LAST_INDEX = 3'd4;

    typedef enum logic [2:0] {
        MSG_NOP,
        MSG_ABSORB,
        MSG_PAD,
        MSG_ZERO,
        MSG_LEN_HI,
        MSG_LEN_LO,
        MSG_SCHED,
        MSG_CLEAR
    } msg_op_t;

    typedef struct packed {
        msg_op_t      op;
        word_t        data;
        logic [2:0]   nbytes;
    } msg_cmd_t;

    typedef struct packed {
        wcount_t wc;
        word_t   w;
    } msg_stat_t;

    typedef enum logic [2:0] {
        RND_NOP,
        RND_INIT,
        RND_LOAD,
        RND_STEP,
        RND_ADD
    } rnd_op_t;

    typedef struct packed {
        rnd_op_t op;
        round_t  round;
        word_t   w;
    } rnd_cmd_t;

    function automatic word_t rotl(word_t v, int k);
        return (v << k) | (v >> (32 - k));
    endfunction

    function automatic word_t round_f(round_t t, word_t b, word_t c, word_t d);
        word_t f;
        if (t < 7'd20)
        begin
            f = (b & c) | (~b & d);
        end
        else if (t < 7'd40)
        begin
            f = b ^ c ^ d;
        end
        else if (t < 7'd60)
        begin
            f = (b & c) | (b & d) | (c & d);
        end
        else
        begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic word_t round_k(round_t t);
        word_t k;
        if (t < 7'd20)
        begin
            k = K0;
        end
        else if (t < 7'd40)
        begin
            k = K1;
        end
        else if (t < 7'd60)
        begin
            k = K2;
        end
        else
        begin
            k = K3;
        end
        return k;
    endfunction

endpackage

[src/sha1_msg.sv]
// Byte packer, 16-word message schedule shift line and 64-bit bit counter.
module sha1_msg (
    input  logic                clk,
    input  logic                rst_n,
    input  sha1_pkg::msg_cmd_t  cmd,
    output sha1_pkg::msg_stat_t stat
);
    import sha1_pkg::*;

    word_t       sched_reg [BLOCK_WORDS];
    logic [23:0] pw_reg;
    logic [23:0] pw_next;
    logic [1:0]  pc_reg;
    logic [1:0]  pc_next;
    wcount_t     wc_reg;
    wcount_t     wc_next;
    logic [63:0] bits_reg;
    logic [63:0] bits_next;

    logic        push;
    word_t       push_word;
    logic [2:0]  nb;
    word_t       data_m;
    logic [2:0]  total;
    logic [55:0] merged;
    word_t       pad_w;
    word_t       feedback;

    always_comb
    begin
        // Oversized counts act as four bytes.
        nb = (cmd.nbytes > 3'd4) ? 3'd4 : cmd.nbytes;
        case (nb)
            3'd0:    data_m = '0;
            3'd1:    data_m = {cmd.data[31:24], 24'h0};
            3'd2:    data_m = {cmd.data[31:16], 16'h0};
            3'd3:    data_m = {cmd.data[31:8], 8'h0};
            default: data_m = cmd.data;
        endcase
        total    = {1'b0, pc_reg} + nb;
        merged   = {pw_reg, 32'h0} | ({24'h0, data_m} << {2'd3 - pc_reg, 3'b000});
        pad_w    = {pw_reg, 8'h00} | (PAD_WORD << {2'd3 - pc_reg, 3'b000});
        feedback = rotl(sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0], 1);
    end

    always_comb
    begin
        push      = 1'b0;
        push_word = '0;
        pw_next   = pw_reg;
        pc_next   = pc_reg;
        wc_next   = wc_reg;
        bits_next = bits_reg;
        case (cmd.op)
            MSG_ABSORB:
            begin
                bits_next = bits_reg + {58'h0, nb, 3'b000};
                pc_next   = total[1:0];
                if (total[2])
                begin
                    push      = 1'b1;
                    push_word = merged[55:24];
                    pw_next   = merged[23:0];
                    wc_next   = wc_reg + 5'd1;
                end
                else
                begin
                    pw_next = merged[55:32];
                end
            end
            MSG_PAD:
            begin
                push      = 1'b1;
                push_word = pad_w;
                pw_next   = '0;
                pc_next   = '0;
                wc_next   = wc_reg + 5'd1;
            end
            MSG_ZERO:
            begin
                push    = 1'b1;
                wc_next = wc_reg + 5'd1;
            end
            MSG_LEN_HI:
            begin
                push      = 1'b1;
                push_word = bits_reg[63:32];
                wc_next   = wc_reg + 5'd1;
            end
            MSG_LEN_LO:
            begin
                push      = 1'b1;
                push_word = bits_reg[31:0];
                wc_next   = wc_reg + 5'd1;
            end
            MSG_SCHED:
            begin
                push      = 1'b1;
                push_word = feedback;
                wc_next   = '0;
            end
            MSG_CLEAR:
            begin
                pw_next   = '0;
                pc_next   = '0;
                wc_next   = '0;
                bits_next = '0;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_reg   <= '0;
            pc_reg   <= '0;
            wc_reg   <= '0;
            bits_reg <= '0;
        end
        else
        begin
            pw_reg   <= pw_next;
            pc_reg   <= pc_next;
            wc_reg   <= wc_next;
            bits_reg <= bits_next;
        end
    end

    // Advance the schedule line: entry 0 is the oldest word.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
            begin
                sched_reg[i] <= sched_reg[i+1];
            end
            sched_reg[BLOCK_WORDS-1] <= push_word;
        end
    end

    assign stat.wc = wc_reg;
    assign stat.w  = sched_reg[0];

endmodule

[src/sha1_round.sv]
// Shared SHA-1 round unit with working registers a..e and chaining hash.
module sha1_round (
    input  logic               clk,
    input  logic               rst_n,
    input  sha1_pkg::rnd_cmd_t cmd,
    output sha1_pkg::digest_t  chain
);
    import sha1_pkg::*;

    digest_t chain_reg;
    digest_t chain_next;
    word_t   a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t   a_next, b_next, c_next, d_next, e_next;
    word_t   t_sum;

    always_comb
    begin
        t_sum = rotl(a_reg, 5) + round_f(cmd.round, b_reg, c_reg, d_reg) + e_reg
              + round_k(cmd.round) + cmd.w;
    end

    always_comb
    begin
        chain_next = chain_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        case (cmd.op)
            RND_INIT:
            begin
                chain_next = IV;
            end
            RND_LOAD:
            begin
                a_next = chain_reg[0];
                b_next = chain_reg[1];
                c_next = chain_reg[2];
                d_next = chain_reg[3];
                e_next = chain_reg[4];
            end
            RND_STEP:
            begin
                a_next = t_sum;
                b_next = a_reg;
                c_next = rotl(b_reg, 30);
                d_next = c_reg;
                e_next = d_reg;
            end
            RND_ADD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                chain_next[4] = chain_reg[4] + e_reg;
            end
            default:
            begin
                chain_next = chain_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= IV;
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
    end

    assign chain = chain_reg;

endmodule

[src/sha1_out.sv]
// Digest output buffer: holds five words and sends them one per transaction.
module sha1_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  sha1_pkg::digest_t digest,
    output logic              busy,
    output logic              valid,
    input  logic              stall,
    output sha1_pkg::word_t   digest_word,
    output sha1_pkg::windex_t word_index,
    output logic              last_word
);
    import sha1_pkg::*;

    digest_t buf_reg;
    digest_t buf_next;
    windex_t idx_reg;
    windex_t idx_next;
    logic    valid_reg;
    logic    valid_next;

    always_comb
    begin
        buf_next   = buf_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (valid_reg)
        begin
            if (!stall)
            begin
                buf_next = buf_reg >> 32;
                idx_next = idx_reg + 3'd1;
                if (idx_reg == LAST_INDEX)
                begin
                    valid_next = 1'b0;
                end
            end
        end
        else if (load)
        begin
            buf_next   = digest;
            idx_next   = '0;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    assign busy        = valid_reg;
    assign valid       = valid_reg;
    assign digest_word = buf_reg[0];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == LAST_INDEX);

endmodule

[src/sha1_hash.sv]
// SHA-1 hash top level: sequencer over the packer, round unit and digest buffer.
//
// Message channel (msg_valid / msg_stall): one transaction carries a big-endian
// word with bytes_valid leading bytes (counts above 4 act as 4) and a last flag.
// Digest channel (digest_valid / digest_stall): after a last transaction the
// block sends five transactions, h0 first, word_index 0..4, last_word on h4.
// Sequence: a message transaction is absorbed, then dispatched. Every
// transaction that completes a 64-byte block adds a load, 80 rounds through
// the single shared round unit, a chaining add and one more dispatch. A last
// transaction then pads one word per cycle, except while a full block
// compresses, and runs one or two more blocks before digest_valid rises,
// later while an earlier digest is still draining.
// No new transaction is taken until the previous one and its block work are
// done; a stream of full words is paced by the one-round-per-cycle compression.
// The digest sits in its own buffer, so the next message may start while the
// receiver stalls; only a second digest waits until the buffer drains.
// Reset: the chaining hash returns to the SHA-1 initial value, byte and bit
// counts clear, no digest is pending. A digest re-primes the block itself.
`include "sha1_hash_macros.svh"

module sha1_hash (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                msg_valid,
    output logic                msg_stall,
    input  logic [31:0]         data_word,
    input  logic [2:0]          bytes_valid,
    input  logic                last,
    output logic                digest_valid,
    input  logic                digest_stall,
    output logic [31:0]         digest_word,
    output logic [2:0]          word_index,
    output logic                last_word
);
    import sha1_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_LOAD,
        S_ROUND,
        S_ADD
    } state_t;

    // Where the message stands once the current block work is done.
    typedef enum logic [1:0] {
        PH_DATA,
        PH_ZERO,
        PH_LEN,
        PH_DONE
    } phase_t;

    state_t    state_reg, state_next;
    phase_t    phase_reg, phase_next;
    logic      last_reg, last_next;
    round_t    round_reg, round_next;

    msg_cmd_t  mcmd;
    msg_stat_t mstat;
    rnd_cmd_t  rcmd;
    digest_t   chain;
    logic      out_load;
    logic      out_busy;
    logic      in_rounds;

    sha1_msg u_msg (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mcmd),
        .stat  (mstat)
    );

    sha1_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (rcmd),
        .chain (chain)
    );

    sha1_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (out_load),
        .digest      (chain),
        .busy        (out_busy),
        .valid       (digest_valid),
        .stall       (digest_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    // Take new transactions only between messages' block work.
    assign msg_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        last_next   = last_reg;
        round_next  = round_reg;
        mcmd.op     = MSG_NOP;
        mcmd.data   = data_word;
        mcmd.nbytes = bytes_valid;
        rcmd.op     = RND_NOP;
        rcmd.round  = round_reg;
        rcmd.w      = mstat.w;
        out_load    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (msg_valid)
                begin
                    mcmd.op    = MSG_ABSORB;
                    last_next  = last;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                // A full block always compresses first.
                if (mstat.wc == WC_FULL)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    case (phase_reg)
                        PH_DATA:
                        begin
                            if (last_reg)
                            begin
                                mcmd.op    = MSG_PAD;
                                phase_next = PH_ZERO;
                            end
                            else
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        PH_ZERO:
                        begin
                            // Zero-fill up to byte 56, then the bit length.
                            if (mstat.wc == WC_LEN)
                            begin
                                mcmd.op    = MSG_LEN_HI;
                                phase_next = PH_LEN;
                            end
                            else
                            begin
                                mcmd.op = MSG_ZERO;
                            end
                        end
                        PH_LEN:
                        begin
                            mcmd.op    = MSG_LEN_LO;
                            phase_next = PH_DONE;
                        end
                        PH_DONE:
                        begin
                            // Hand off the digest, then re-prime for a new message.
                            if (!out_busy)
                            begin
                                out_load   = 1'b1;
                                rcmd.op    = RND_INIT;
                                mcmd.op    = MSG_CLEAR;
                                phase_next = PH_DATA;
                                last_next  = 1'b0;
                                state_next = S_IDLE;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                rcmd.op    = RND_LOAD;
                round_next = '0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                rcmd.op = RND_STEP;
                mcmd.op = MSG_SCHED;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = S_ADD;
                end
                else
                begin
                    round_next = round_reg + 7'd1;
                end
            end
            S_ADD:
            begin
                rcmd.op    = RND_ADD;
                state_next = S_DISPATCH;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_DATA;
            last_reg  <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            last_reg  <= last_next;
            round_reg <= round_next;
        end
    end

    assign in_rounds = (state_reg == S_ROUND) && (round_reg != LAST_ROUND);

    `SHA1_ASSERT_IMP(a_load_full, state_reg == S_LOAD, mstat.wc == WC_FULL, "partial block load")
    `SHA1_ASSERT_NXT(a_round_hold, in_rounds, state_reg == S_ROUND, "round loop left early")
    `SHA1_ASSERT_IMP(a_wc_range, 1'b1, mstat.wc <= WC_FULL, "word count past block size")
    `SHA1_ASSERT_IMP(a_digest_free, out_load, !digest_valid, "digest load while busy")

endmodule

[tb/testbench.sv]
// Self-checking testbench for the SHA-1 hash block with a built-in digest predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Message transaction as queued for the driver; gap is the number of idle
    // cycles to hold valid low before this transaction goes on the bus.
    typedef struct {
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic        last;
        int          gap;
    } msg_item_t;

    // One expected digest transaction.
    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last_word;
    } digest_item_t;

    localparam logic [31:0] H_INIT [5] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                          32'h10325476, 32'hC3D2E1F0};
    localparam logic [31:0] RK0 = 32'h5A827999;
    localparam logic [31:0] RK1 = 32'h6ED9EBA1;
    localparam logic [31:0] RK2 = 32'h8F1BBCDC;
    localparam logic [31:0] RK3 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          DRAIN_CYCLES = 200;
    localparam int          ITEM_TARGET = 320;
    localparam int          SHOWN_MISMATCHES = 10;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        msg_valid;
    logic        msg_stall;
    logic [31:0] data_word;
    logic [2:0]  bytes_valid;
    logic        last;
    logic        digest_valid;
    logic        digest_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    sha1_hash u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .data_word    (data_word),
        .bytes_valid  (bytes_valid),
        .last         (last),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest_word  (digest_word),
        .word_index   (word_index),
        .last_word    (last_word)
    );

    // 2 ns period clock.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    msg_item_t    msg_queue[$];
    digest_item_t expected_digest[$];
    int           mismatch_count = 0;
    int           quiet_cycles = 0;
    logic         msg_taken = 1'b0;
    logic         digest_taken = 1'b0;

    // ------------------------------------------------------------------
    // Digest predictor: its own chaining hash, block buffer, byte fill
    // and message bit length, advanced one accepted transaction at a time.
    // ------------------------------------------------------------------
    logic [31:0] chain_h [5];
    logic [31:0] block_words [16];
    logic [5:0]  block_fill_cnt;
    logic [63:0] msg_bits;

    function automatic logic [31:0] rotate_left(logic [31:0] v, int k);
        return (v << k) | (v >> (32 - k));
    endfunction

    // Run the 80 rounds on the full block buffer and fold into the chain.
    function automatic void compress_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t_new;
        for (int t = 0; t < 16; t++)
        begin
            w[t] = block_words[t];
        end
        for (int t = 16; t < 80; t++)
        begin
            w[t] = rotate_left(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int t = 0; t < 80; t++)
        begin
            if (t < 20)
            begin
                f = (b & c) | (~b & d);
                k = RK0;
            end
            else if (t < 40)
            begin
                f = b ^ c ^ d;
                k = RK1;
            end
            else if (t < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = RK2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = RK3;
            end
            t_new = rotate_left(a, 5) + f + e + k + w[t];
            e = d;
            d = c;
            c = rotate_left(b, 30);
            b = a;
            a = t_new;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    // Drop one byte into the block buffer; a full block compresses at once.
    function automatic void append_byte(logic [7:0] value);
        int idx;
        int sh;
        idx = block_fill_cnt[5:2];
        sh = 24 - 8 * block_fill_cnt[1:0];
        block_words[idx][sh +: 8] = value;
        block_fill_cnt = block_fill_cnt + 6'd1;
        if (block_fill_cnt == 6'd0)
        begin
            compress_block();
        end
    endfunction

    function automatic void restart_message();
        chain_h = H_INIT;
        block_fill_cnt = '0;
        msg_bits = '0;
    endfunction

    // Absorb one accepted message transaction; a last one pads, closes the
    // message and queues the five digest words.
    function automatic void absorb_word(logic [31:0] word, logic [2:0] nbytes, logic fin);
        int          n;
        logic [63:0] len;
        digest_item_t d;
        n = (nbytes > 3'd4) ? 4 : int'(nbytes);
        for (int i = 0; i < n; i++)
        begin
            append_byte(word[31 - 8*i -: 8]);
        end
        msg_bits += 64'(n * 8);
        if (fin)
        begin
            len = msg_bits;
            append_byte(PAD_BYTE);
            while (block_fill_cnt != 6'd56)
            begin
                append_byte(8'h00);
            end
            for (int i = 0; i < 8; i++)
            begin
                append_byte(len[63 - 8*i -: 8]);
            end
            for (int i = 0; i < 5; i++)
            begin
                d.word = chain_h[i];
                d.index = 3'(i);
                d.last_word = (i == 4);
                expected_digest.push_back(d);
            end
            restart_message();
        end
    endfunction

    // ------------------------------------------------------------------
    // Message driver: change inputs on the falling edge, hold a stalled
    // transaction, and wait out each transaction's gap before presenting it.
    // ------------------------------------------------------------------
    int idle_cnt = 0;

    always @(negedge clk)
    begin
        logic      hold;
        logic      present;
        msg_item_t item;
        present = 1'b0;
        if (rst_n)
        begin
            hold = msg_valid && !msg_taken;
            if (!hold)
            begin
                if (msg_queue.size() > 0 && idle_cnt >= msg_queue[0].gap)
                begin
                    item = msg_queue.pop_front();
                    data_word <= item.data;
                    bytes_valid <= item.nbytes;
                    last <= item.last;
                    present = 1'b1;
                    idle_cnt = 0;
                end
                else
                begin
                    idle_cnt++;
                end
            end
            msg_valid <= hold || present;
        end
    end

    // ------------------------------------------------------------------
    // Digest receiver stall: after each accepted digest transaction draw a
    // random stall length up to stall_max; every fifteen results pick at random
    // between stalling and a stretch with no stalls at all.
    // ------------------------------------------------------------------
    int stall_left = 0;
    int stall_max = 7;
    int results_seen = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (digest_taken)
            begin
                results_seen++;
                if (results_seen % 15 == 0)
                begin
                    stall_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
                end
                stall_left = $urandom_range(0, stall_max);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            digest_stall <= (stall_left > 0);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge, predict on every
    // accepted message transaction, check every accepted digest transaction
    // against the oldest expectation, and run the watchdog.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        digest_item_t exp_item;
        logic         msg_fire;
        logic         digest_fire;
        if (rst_n)
        begin
            msg_fire = msg_valid && !msg_stall;
            digest_fire = digest_valid && !digest_stall;
            msg_taken <= msg_fire;
            digest_taken <= digest_fire;

            if (msg_fire)
            begin
                absorb_word(data_word, bytes_valid, last);
            end

            if (digest_fire)
            begin
                if (expected_digest.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_MISMATCHES)
                    begin
                        $display("[%0t] unexpected digest transaction: word %h index %0d last %b",
                                 $realtime, digest_word, word_index, last_word);
                    end
                end
                else
                begin
                    exp_item = expected_digest.pop_front();
                    if (digest_word !== exp_item.word || word_index !== exp_item.index ||
                        last_word !== exp_item.last_word)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= SHOWN_MISMATCHES)
                        begin
                            $display("[%0t] digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                                     $realtime, exp_item.word, exp_item.index,
                                     exp_item.last_word, digest_word, word_index, last_word);
                        end
                    end
                end
            end

            // Restart the watchdog on any transaction; give up after a long silence.
            if (msg_fire || digest_fire)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    function automatic void queue_item(logic [31:0] data, logic [2:0] nbytes, logic fin,
                                       logic burst);
        msg_item_t item;
        item.data = data;
        item.nbytes = nbytes;
        item.last = fin;
        item.gap = burst ? 0 : $urandom_range(0, 7);
        msg_queue.push_back(item);
    endfunction

    function automatic logic [31:0] random_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            return 32'h0000_0000;
        end
        else if (pick == 1)
        begin
            return 32'hFFFF_FFFF;
        end
        return $urandom;
    endfunction

    initial
    begin
        int   queued;
        int   msg_len;
        logic burst;
        logic [2:0] nb;

        // Hold every input at a known value from time zero.
        rst_n = 1'b0;
        msg_valid = 1'b0;
        data_word = '0;
        bytes_valid = '0;
        last = 1'b0;
        digest_stall = 1'b0;
        restart_message();
        for (int i = 0; i < 16; i++)
        begin
            block_words[i] = '0;
        end

        // Directed part.
        // Empty message: a last transaction with no bytes.
        queue_item(32'hFFFF_FFFF, 3'd0, 1'b1, 1'b0);
        // Three-byte message in one short last transaction.
        queue_item(32'h6162_6300, 3'd3, 1'b1, 1'b0);
        // Oversized byte counts act as four, on plain and last transactions.
        queue_item(32'hFFFF_FFFF, 3'd5, 1'b0, 1'b1);
        queue_item(32'h0000_0000, 3'd6, 1'b0, 1'b1);
        queue_item(32'hA5C3_5A3C, 3'd7, 1'b1, 1'b1);
        // Short words before the end, an empty transaction mid-message.
        queue_item(32'h1234_5678, 3'd1, 1'b0, 1'b0);
        queue_item(32'h9ABC_DEF0, 3'd2, 1'b0, 1'b0);
        queue_item(32'h0F1E_2D3C, 3'd3, 1'b0, 1'b0);
        queue_item(32'hDEAD_BEEF, 3'd0, 1'b0, 1'b0);
        queue_item(32'hFFFF_FFFF, 3'd4, 1'b1, 1'b0);
        // 56-byte message: the length no longer fits, padding spills into a second block.
        for (int i = 0; i < 14; i++)
        begin
            queue_item((i % 2 == 0) ? 32'hFFFF_FFFF : 32'h0000_0000, 3'd4, i == 13, 1'b1);
        end
        queued = msg_queue.size();

        // Random part: whole messages with random content, mostly short,
        // some spanning several blocks, with noise in the byte counts.
        while (queued < ITEM_TARGET)
        begin
            msg_len = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 40)
                                                  : $urandom_range(1, 16);
            burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < msg_len; i++)
            begin
                if (i == msg_len - 1)
                begin
                    nb = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7))
                                                     : 3'($urandom_range(0, 4));
                end
                else
                begin
                    nb = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
                end
                queue_item(random_word(), nb, i == msg_len - 1, burst);
            end
            queued += msg_len;
        end

        // Release reset on a falling edge.
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Wait for all transactions to go out and every digest to come back.
        while (msg_queue.size() > 0 || msg_valid)
        begin
            @(posedge clk);
        end
        while (expected_digest.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
